[hw/rtl/bpa_pkg.sv]
// Shared types, codes and constants of the buddy page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int NUM_PAGES_DEF   = 1024;
   localparam int ORDER_COUNT_DEF = 10;
   localparam int HUGE_ORDER_DEF  = 9;

   localparam int CMD_W       = 2;
   localparam int PAGE_W      = 10;
   localparam int QORD_W      = 4;
   localparam int ORD_OUT_W   = 4;
   localparam int CNT_OUT_W   = 11;
   localparam int ORD_STORE_W = 4;
   localparam int ORD_W       = 5;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_SEARCH, ST_UNL_RD, ST_UNL_WR,
      ST_SPLIT, ST_SPLIT_CHK, ST_SPLIT_DAT, ST_SPLIT_PUSH,
      ST_PUSH, ST_PUSH_DAT, ST_PUSH_LINK,
      ST_FREE_RD, ST_FREE_DAT, ST_MERGE, ST_MERGE_DAT, ST_MERGE_UPD,
      ST_MERGE_UPD2, ST_FIN, ST_RSP_ZERO, ST_RSP_BLOCK, ST_RSP_QUERY
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_CLEAR, DP_LOAD, DP_SRCH_NEXT, DP_TAKE, DP_LINK_RD, DP_UNL_WR,
      DP_SPLIT_STEP, DP_ALLOC_END, DP_META_RD_BUD, DP_LIDX_RD, DP_SPLIT_MARK,
      DP_PUSH_SOLO, DP_PUSH_RD, DP_PUSH_LINK1, DP_PUSH_LINK2,
      DP_META_RD_PG, DP_FREE_ORD, DP_MERGE_RD, DP_MERGE_TAKE, DP_MERGE_UPD,
      DP_MERGE_UPD2, DP_FIN, DP_RSP_ZERO, DP_RSP_BLOCK, DP_RSP_QUERY
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      take;
   } dp_cmd_type;

   typedef struct packed {
      logic             req_valid;
      logic [CMD_W-1:0] cmd;
      logic             page_bad;
      logic             srch_out;
      logic             cnt_zero;
      logic             split_more;
      logic             split_bud_ok;
      logic             rd_free;
      logic             ord_match;
      logic             merge_go;
      logic             slot_free;
      logic             clr_last;
   } dp_status_type;

endpackage

[hw/rtl/bpa_req_if.sv]
// Request channel: command transaction into the allocator.
`timescale 1ns / 1ps

interface bpa_req_if;
   logic                         valid;
   logic                         ready;
   logic [bpa_pkg::CMD_W-1:0]    command;
   logic                         huge_request;
   logic [bpa_pkg::PAGE_W-1:0]   page_index;
   logic [bpa_pkg::QORD_W-1:0]   query_order;

   modport source (output valid, command, huge_request, page_index, query_order,
                   input ready);
   modport sink (input valid, command, huge_request, page_index, query_order,
                 output ready);
endinterface

[hw/rtl/bpa_rsp_if.sv]
// Response channel: result transaction out of the allocator.
`timescale 1ns / 1ps

interface bpa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           success;
   logic [bpa_pkg::PAGE_W-1:0]     block_page;
   logic [bpa_pkg::ORD_OUT_W-1:0]  block_order;
   logic [bpa_pkg::CNT_OUT_W-1:0]  free_blocks;

   modport source (output valid, success, block_page, block_order, free_blocks,
                   input ready);
   modport sink (input valid, success, block_page, block_order, free_blocks,
                 output ready);
endinterface

[hw/rtl/buddy_page_allocator.sv]
// Buddy page allocator top level: sequencer plus datapath.
// After reset the block clears its per-page order and free stores page by page
// and takes no request meanwhile. A request then runs alone through a sequencer
// over page stores with one write port and one registered read port each. A
// query, an unknown command, an out-of-range free and a double free get their
// response without list work; an allocate searches the orders upward from the
// requested one, unlinks the head block it finds and splits it level by level,
// unlinking a free buddy before pushing it and skipping a buddy that lies past
// the last page; a failed allocate ends after the search; a free merges level
// by level with a free buddy of the same order. Each level uses read-then-write
// steps on the link and order stores. Results wait in an output register, so
// the next request is taken while a response is still pending; a request whose
// response finds that register still full waits until it drains.
`timescale 1ns / 1ps

module buddy_page_allocator #(
   parameter int NUM_PAGES   = bpa_pkg::NUM_PAGES_DEF,
   parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF,
   parameter int HUGE_ORDER  = bpa_pkg::HUGE_ORDER_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bpa_req_if.sink    req_ch,
   bpa_rsp_if.source  rsp_ch
);

   bpa_pkg::dp_cmd_type    dp;
   bpa_pkg::dp_status_type st;

   bpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .dp    (dp)
   );

   bpa_datapath #(
      .NUM_PAGES   (NUM_PAGES),
      .ORDER_COUNT (ORDER_COUNT),
      .HUGE_ORDER  (HUGE_ORDER)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .dp     (dp),
      .st     (st),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

[hw/rtl/bpa_ctrl.sv]
// Sequencer that steps the datapath through allocate, free and query.
`timescale 1ns / 1ps

module bpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  bpa_pkg::dp_status_type st,
   output bpa_pkg::dp_cmd_type    dp
);

   bpa_pkg::state_type state_ff, state_in;
   bpa_pkg::state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::ST_CLEAR;
         ret_ff   <= bpa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         bpa_pkg::ST_CLEAR: if (st.clr_last) state_in = bpa_pkg::ST_IDLE;
         bpa_pkg::ST_IDLE: if (st.req_valid) state_in = bpa_pkg::ST_DISPATCH;
         bpa_pkg::ST_DISPATCH: begin
            case (st.cmd)
               bpa_pkg::CMD_ALLOC: state_in = bpa_pkg::ST_SEARCH;
               bpa_pkg::CMD_FREE:
                  state_in = st.page_bad ? bpa_pkg::ST_RSP_ZERO : bpa_pkg::ST_FREE_RD;
               bpa_pkg::CMD_QUERY: state_in = bpa_pkg::ST_RSP_QUERY;
               default: state_in = bpa_pkg::ST_RSP_ZERO;
            endcase
         end
         bpa_pkg::ST_SEARCH: begin
            if (st.srch_out) begin
               state_in = bpa_pkg::ST_RSP_ZERO;
            end else if (!st.cnt_zero) begin
               state_in = bpa_pkg::ST_UNL_RD;
               ret_in   = bpa_pkg::ST_SPLIT;
            end
         end
         bpa_pkg::ST_UNL_RD: state_in = bpa_pkg::ST_UNL_WR;
         bpa_pkg::ST_UNL_WR: state_in = ret_ff;
         bpa_pkg::ST_SPLIT: begin
            if (!st.split_more) state_in = bpa_pkg::ST_RSP_BLOCK;
            else if (st.split_bud_ok) state_in = bpa_pkg::ST_SPLIT_CHK;
         end
         bpa_pkg::ST_SPLIT_CHK: state_in = bpa_pkg::ST_SPLIT_DAT;
         bpa_pkg::ST_SPLIT_DAT: begin
            if (st.rd_free) begin
               state_in = bpa_pkg::ST_UNL_RD;
               ret_in   = bpa_pkg::ST_SPLIT_PUSH;
            end else begin
               state_in = bpa_pkg::ST_SPLIT_PUSH;
            end
         end
         bpa_pkg::ST_SPLIT_PUSH: begin
            state_in = bpa_pkg::ST_PUSH;
            ret_in   = bpa_pkg::ST_SPLIT;
         end
         bpa_pkg::ST_PUSH: state_in = st.cnt_zero ? ret_ff : bpa_pkg::ST_PUSH_DAT;
         bpa_pkg::ST_PUSH_DAT: state_in = bpa_pkg::ST_PUSH_LINK;
         bpa_pkg::ST_PUSH_LINK: state_in = ret_ff;
         bpa_pkg::ST_FREE_RD: state_in = bpa_pkg::ST_FREE_DAT;
         bpa_pkg::ST_FREE_DAT:
            state_in = st.rd_free ? bpa_pkg::ST_RSP_ZERO : bpa_pkg::ST_MERGE;
         bpa_pkg::ST_MERGE:
            state_in = st.merge_go ? bpa_pkg::ST_MERGE_DAT : bpa_pkg::ST_FIN;
         bpa_pkg::ST_MERGE_DAT: begin
            if (st.rd_free && st.ord_match) begin
               state_in = bpa_pkg::ST_UNL_RD;
               ret_in   = bpa_pkg::ST_MERGE_UPD;
            end else begin
               state_in = bpa_pkg::ST_FIN;
            end
         end
         bpa_pkg::ST_MERGE_UPD: state_in = bpa_pkg::ST_MERGE_UPD2;
         bpa_pkg::ST_MERGE_UPD2: state_in = bpa_pkg::ST_MERGE;
         bpa_pkg::ST_FIN: begin
            state_in = bpa_pkg::ST_PUSH;
            ret_in   = bpa_pkg::ST_RSP_BLOCK;
         end
         bpa_pkg::ST_RSP_ZERO, bpa_pkg::ST_RSP_BLOCK, bpa_pkg::ST_RSP_QUERY:
            if (st.slot_free) state_in = bpa_pkg::ST_IDLE;
         default: state_in = bpa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      dp.op   = bpa_pkg::DP_NOP;
      dp.take = 1'b0;
      case (state_ff)
         bpa_pkg::ST_CLEAR: dp.op = bpa_pkg::DP_CLEAR;
         bpa_pkg::ST_IDLE: begin
            dp.take = 1'b1;
            if (st.req_valid) dp.op = bpa_pkg::DP_LOAD;
         end
         bpa_pkg::ST_SEARCH: begin
            if (!st.srch_out)
               dp.op = st.cnt_zero ? bpa_pkg::DP_SRCH_NEXT : bpa_pkg::DP_TAKE;
         end
         bpa_pkg::ST_UNL_RD: dp.op = bpa_pkg::DP_LINK_RD;
         bpa_pkg::ST_UNL_WR: dp.op = bpa_pkg::DP_UNL_WR;
         bpa_pkg::ST_SPLIT:
            dp.op = st.split_more ? bpa_pkg::DP_SPLIT_STEP : bpa_pkg::DP_ALLOC_END;
         bpa_pkg::ST_SPLIT_CHK: dp.op = bpa_pkg::DP_META_RD_BUD;
         bpa_pkg::ST_SPLIT_DAT: if (st.rd_free) dp.op = bpa_pkg::DP_LIDX_RD;
         bpa_pkg::ST_SPLIT_PUSH: dp.op = bpa_pkg::DP_SPLIT_MARK;
         bpa_pkg::ST_PUSH:
            dp.op = st.cnt_zero ? bpa_pkg::DP_PUSH_SOLO : bpa_pkg::DP_PUSH_RD;
         bpa_pkg::ST_PUSH_DAT: dp.op = bpa_pkg::DP_PUSH_LINK1;
         bpa_pkg::ST_PUSH_LINK: dp.op = bpa_pkg::DP_PUSH_LINK2;
         bpa_pkg::ST_FREE_RD: dp.op = bpa_pkg::DP_META_RD_PG;
         bpa_pkg::ST_FREE_DAT: if (!st.rd_free) dp.op = bpa_pkg::DP_FREE_ORD;
         bpa_pkg::ST_MERGE: if (st.merge_go) dp.op = bpa_pkg::DP_MERGE_RD;
         bpa_pkg::ST_MERGE_DAT:
            if (st.rd_free && st.ord_match) dp.op = bpa_pkg::DP_MERGE_TAKE;
         bpa_pkg::ST_MERGE_UPD: dp.op = bpa_pkg::DP_MERGE_UPD;
         bpa_pkg::ST_MERGE_UPD2: dp.op = bpa_pkg::DP_MERGE_UPD2;
         bpa_pkg::ST_FIN: dp.op = bpa_pkg::DP_FIN;
         bpa_pkg::ST_RSP_ZERO: if (st.slot_free) dp.op = bpa_pkg::DP_RSP_ZERO;
         bpa_pkg::ST_RSP_BLOCK: if (st.slot_free) dp.op = bpa_pkg::DP_RSP_BLOCK;
         bpa_pkg::ST_RSP_QUERY: if (st.slot_free) dp.op = bpa_pkg::DP_RSP_QUERY;
         default: dp.op = bpa_pkg::DP_NOP;
      endcase
   end

endmodule

[hw/rtl/bpa_datapath.sv]
// Page stores, free lists, working registers and response register.
`timescale 1ns / 1ps

module bpa_datapath #(
   parameter int NUM_PAGES   = bpa_pkg::NUM_PAGES_DEF,
   parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF,
   parameter int HUGE_ORDER  = bpa_pkg::HUGE_ORDER_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bpa_pkg::dp_cmd_type     dp,
   output bpa_pkg::dp_status_type  st,
   bpa_req_if.sink                 req_ch,
   bpa_rsp_if.source               rsp_ch
);

   localparam int AW = $clog2(NUM_PAGES);
   localparam int LW = $clog2(ORDER_COUNT);
   localparam int CW = $clog2(NUM_PAGES + 1);
   localparam int PW = (AW > ORDER_COUNT) ? AW : ORDER_COUNT;
   localparam int OW = bpa_pkg::ORD_W;
   localparam int SW = bpa_pkg::ORD_STORE_W;

   logic [SW-1:0] ord_store_ff [NUM_PAGES];
   logic          free_store_ff [NUM_PAGES];
   logic [AW-1:0] next_store_ff [NUM_PAGES];
   logic [AW-1:0] prev_store_ff [NUM_PAGES];

   logic [SW-1:0] ord_q_ff;
   logic          free_q_ff;
   logic [AW-1:0] next_q_ff, prev_q_ff;

   logic [AW-1:0] head_ff [ORDER_COUNT];
   logic [AW-1:0] head_in [ORDER_COUNT];
   logic [CW-1:0] cnt_ff [ORDER_COUNT];
   logic [CW-1:0] cnt_in [ORDER_COUNT];

   logic [bpa_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic          page_bad_ff, page_bad_in;
   logic [AW-1:0] pg_ff, pg_in;
   logic [OW-1:0] req_ff, req_in;
   logic [OW-1:0] ord_ff, ord_in;
   logic [OW-1:0] lidx_ff, lidx_in;
   logic [AW-1:0] bud_ff, bud_in;
   logic [AW-1:0] tgt_ff, tgt_in;
   logic [AW-1:0] t_ff, t_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_success_ff, rsp_success_in;
   logic [bpa_pkg::PAGE_W-1:0]      rsp_page_ff, rsp_page_in;
   logic [bpa_pkg::ORD_OUT_W-1:0]   rsp_ord_ff, rsp_ord_in;
   logic [bpa_pkg::CNT_OUT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic [LW-1:0] li;
   logic          lidx_ok;
   logic [AW-1:0] head_sel;
   logic [CW-1:0] cnt_sel;
   logic          cnt_zero;
   logic [PW-1:0] bud_w, bud_split_w;
   logic          bud_ok;
   logic [OW-1:0] start_ord;

   logic          ord_we, free_we, next_we, prev_we, free_wd;
   logic [AW-1:0] ord_wa, free_wa, next_wa, prev_wa, next_wd, prev_wd;
   logic [SW-1:0] ord_wd;
   logic [AW-1:0] meta_ra, link_ra;

   assign li       = lidx_ff[LW-1:0];
   assign lidx_ok  = 32'(lidx_ff) < 32'(ORDER_COUNT);
   assign head_sel = head_ff[li];
   assign cnt_sel  = cnt_ff[li];
   assign cnt_zero = !lidx_ok || (cnt_sel == '0);
   assign bud_w       = PW'(pg_ff) ^ (PW'(1) << ord_ff);
   assign bud_split_w = PW'(pg_ff) ^ (PW'(1) << (ord_ff - OW'(1)));
   assign bud_ok      = 32'(bud_w) < 32'(NUM_PAGES);
   assign start_ord   = req_ch.huge_request ? OW'(HUGE_ORDER) : '0;

   assign st.req_valid    = req_ch.valid;
   assign st.cmd          = cmd_ff;
   assign st.page_bad     = page_bad_ff;
   assign st.srch_out     = 32'(ord_ff) >= 32'(ORDER_COUNT);
   assign st.cnt_zero     = cnt_zero;
   assign st.split_more   = ord_ff > req_ff;
   assign st.split_bud_ok = 32'(bud_split_w) < 32'(NUM_PAGES);
   assign st.rd_free      = free_q_ff;
   assign st.ord_match    = OW'(ord_q_ff) == ord_ff;
   assign st.merge_go     = (32'(ord_ff) + 1 < 32'(ORDER_COUNT)) && bud_ok;
   assign st.slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign st.clr_last     = 32'(clr_ff) == 32'(NUM_PAGES - 1);

   assign req_ch.ready       = dp.take;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.success     = rsp_success_ff;
   assign rsp_ch.block_page  = rsp_page_ff;
   assign rsp_ch.block_order = rsp_ord_ff;
   assign rsp_ch.free_blocks = rsp_cnt_ff;

   always_comb begin
      cmd_in      = cmd_ff;
      page_bad_in = page_bad_ff;
      pg_in       = pg_ff;
      req_in      = req_ff;
      ord_in      = ord_ff;
      lidx_in     = lidx_ff;
      bud_in      = bud_ff;
      tgt_in      = tgt_ff;
      t_in        = t_ff;
      clr_in      = clr_ff;
      case (dp.op)
         bpa_pkg::DP_LOAD: begin
            cmd_in      = req_ch.command;
            page_bad_in = 32'(req_ch.page_index) >= 32'(NUM_PAGES);
            pg_in       = AW'(req_ch.page_index);
            req_in      = start_ord;
            ord_in      = start_ord;
            lidx_in     = (req_ch.command == bpa_pkg::CMD_QUERY) ?
                          OW'(req_ch.query_order) : start_ord;
         end
         bpa_pkg::DP_SRCH_NEXT: begin
            ord_in  = ord_ff + OW'(1);
            lidx_in = ord_ff + OW'(1);
         end
         bpa_pkg::DP_TAKE: begin
            pg_in  = head_sel;
            tgt_in = head_sel;
         end
         bpa_pkg::DP_SPLIT_STEP: begin
            ord_in = ord_ff - OW'(1);
            bud_in = AW'(bud_split_w);
            tgt_in = AW'(bud_split_w);
         end
         bpa_pkg::DP_LIDX_RD: lidx_in = OW'(ord_q_ff);
         bpa_pkg::DP_SPLIT_MARK: lidx_in = ord_ff;
         bpa_pkg::DP_PUSH_LINK1: t_in = prev_q_ff;
         bpa_pkg::DP_FREE_ORD:
            ord_in = (32'(ord_q_ff) >= 32'(ORDER_COUNT)) ?
                     OW'(ORDER_COUNT - 1) : OW'(ord_q_ff);
         bpa_pkg::DP_MERGE_RD: begin
            bud_in = AW'(bud_w);
            tgt_in = AW'(bud_w);
         end
         bpa_pkg::DP_MERGE_TAKE: lidx_in = ord_ff;
         bpa_pkg::DP_MERGE_UPD: begin
            ord_in = ord_ff + OW'(1);
            if (bud_ff < pg_ff) pg_in = bud_ff;
         end
         bpa_pkg::DP_FIN: begin
            tgt_in  = pg_ff;
            lidx_in = ord_ff;
         end
         bpa_pkg::DP_CLEAR: clr_in = clr_ff + AW'(1);
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_success_in = rsp_success_ff;
      rsp_page_in    = rsp_page_ff;
      rsp_ord_in     = rsp_ord_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      case (dp.op)
         bpa_pkg::DP_RSP_ZERO: begin
            rsp_valid_in   = 1'b1;
            rsp_success_in = 1'b0;
            rsp_page_in    = '0;
            rsp_ord_in     = '0;
            rsp_cnt_in     = '0;
         end
         bpa_pkg::DP_RSP_BLOCK: begin
            rsp_valid_in   = 1'b1;
            rsp_success_in = 1'b1;
            rsp_page_in    = bpa_pkg::PAGE_W'(pg_ff);
            rsp_ord_in     = bpa_pkg::ORD_OUT_W'(ord_ff);
            rsp_cnt_in     = '0;
         end
         bpa_pkg::DP_RSP_QUERY: begin
            rsp_valid_in   = 1'b1;
            rsp_success_in = 1'b1;
            rsp_page_in    = '0;
            rsp_ord_in     = '0;
            rsp_cnt_in     = lidx_ok ? bpa_pkg::CNT_OUT_W'(cnt_sel) : '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      ord_we  = 1'b0;
      ord_wa  = pg_ff;
      ord_wd  = SW'(ord_ff);
      free_we = 1'b0;
      free_wa = bud_ff;
      free_wd = 1'b0;
      next_we = 1'b0;
      next_wa = tgt_ff;
      next_wd = tgt_ff;
      prev_we = 1'b0;
      prev_wa = tgt_ff;
      prev_wd = tgt_ff;
      meta_ra = bud_ff;
      link_ra = tgt_ff;
      case (dp.op)
         bpa_pkg::DP_CLEAR: begin
            ord_we  = 1'b1;
            ord_wa  = clr_ff;
            ord_wd  = '0;
            free_we = 1'b1;
            free_wa = clr_ff;
         end
         bpa_pkg::DP_TAKE: begin
            free_we = 1'b1;
            free_wa = head_sel;
         end
         bpa_pkg::DP_UNL_WR: begin
            next_we = !cnt_zero;
            next_wa = prev_q_ff;
            next_wd = next_q_ff;
            prev_we = !cnt_zero;
            prev_wa = next_q_ff;
            prev_wd = prev_q_ff;
         end
         bpa_pkg::DP_ALLOC_END: begin
            ord_we = 1'b1;
            ord_wd = SW'(req_ff);
         end
         bpa_pkg::DP_SPLIT_MARK: begin
            ord_we  = 1'b1;
            ord_wa  = bud_ff;
            free_we = 1'b1;
            free_wd = 1'b1;
         end
         bpa_pkg::DP_PUSH_SOLO: begin
            next_we = 1'b1;
            prev_we = 1'b1;
         end
         bpa_pkg::DP_PUSH_RD: link_ra = head_sel;
         bpa_pkg::DP_PUSH_LINK1: begin
            next_we = 1'b1;
            next_wd = head_sel;
            prev_we = 1'b1;
            prev_wd = prev_q_ff;
         end
         bpa_pkg::DP_PUSH_LINK2: begin
            next_we = 1'b1;
            next_wa = t_ff;
            prev_we = 1'b1;
            prev_wa = head_sel;
         end
         bpa_pkg::DP_META_RD_PG: meta_ra = pg_ff;
         bpa_pkg::DP_MERGE_RD: meta_ra = AW'(bud_w);
         bpa_pkg::DP_MERGE_TAKE: free_we = 1'b1;
         bpa_pkg::DP_MERGE_UPD: begin
            ord_we = 1'b1;
            ord_wa = bud_ff;
            ord_wd = SW'(ord_ff + OW'(1));
         end
         bpa_pkg::DP_MERGE_UPD2: ord_we = 1'b1;
         bpa_pkg::DP_FIN: begin
            ord_we  = 1'b1;
            free_we = 1'b1;
            free_wa = pg_ff;
            free_wd = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      head_in = head_ff;
      cnt_in  = cnt_ff;
      case (dp.op)
         bpa_pkg::DP_UNL_WR: begin
            if (!cnt_zero) begin
               if (head_sel == tgt_ff) head_in[li] = next_q_ff;
               cnt_in[li] = cnt_sel - CW'(1);
            end
         end
         bpa_pkg::DP_PUSH_SOLO, bpa_pkg::DP_PUSH_LINK2: begin
            if (lidx_ok) begin
               head_in[li] = tgt_ff;
               cnt_in[li]  = cnt_sel + CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ord_we) ord_store_ff[ord_wa] <= ord_wd;
      if (free_we) free_store_ff[free_wa] <= free_wd;
      ord_q_ff  <= ord_store_ff[meta_ra];
      free_q_ff <= free_store_ff[meta_ra];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_store_ff[next_wa] <= next_wd;
      if (prev_we) prev_store_ff[prev_wa] <= prev_wd;
      next_q_ff <= next_store_ff[link_ra];
      prev_q_ff <= prev_store_ff[link_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '{default: '0};
         cnt_ff       <= '{default: '0};
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      page_bad_ff    <= page_bad_in;
      pg_ff          <= pg_in;
      req_ff         <= req_in;
      ord_ff         <= ord_in;
      lidx_ff        <= lidx_in;
      bud_ff         <= bud_in;
      tgt_ff         <= tgt_in;
      t_ff           <= t_in;
      rsp_success_ff <= rsp_success_in;
      rsp_page_ff    <= rsp_page_in;
      rsp_ord_ff     <= rsp_ord_in;
      rsp_cnt_ff     <= rsp_cnt_in;
   end

   a_split_above_req: assert property (@(posedge clock) disable iff (reset)
      dp.op == bpa_pkg::DP_SPLIT_STEP |-> ord_ff > req_ff)
      else $error("split below requested order");

   a_alloc_at_req: assert property (@(posedge clock) disable iff (reset)
      dp.op == bpa_pkg::DP_ALLOC_END |-> ord_ff == req_ff)
      else $error("allocated block order differs from request");

   a_merge_top: assert property (@(posedge clock) disable iff (reset)
      dp.op == bpa_pkg::DP_FIN |-> 32'(ord_ff) < 32'(ORDER_COUNT))
      else $error("merged order past top order");

   a_push_list: assert property (@(posedge clock) disable iff (reset)
      (dp.op == bpa_pkg::DP_PUSH_SOLO || dp.op == bpa_pkg::DP_PUSH_LINK2)
      |-> lidx_ok)
      else $error("push to a list that does not exist");

endmodule
